[rtl/mgbd_pkg.sv]
`timescale 1ns / 1ps

package mgbd_pkg;

  localparam int unsigned MAX_SENSORS_DEFAULT = 16;

  localparam int unsigned SENSOR_W   = 4;
  localparam int unsigned POS_W      = 32;
  localparam int unsigned THR_W      = 31;
  localparam int unsigned DELAY_W    = 8;
  localparam int unsigned PEAK_W     = 33;
  localparam int unsigned MAG_W      = 31;
  localparam int unsigned SQ_W       = 2 * MAG_W;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 31;

  localparam int unsigned QUEUE_DEPTH = 4;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_Z_THRESHOLD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_FLOOR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF_DELAY = 2'd2;

  localparam logic [THR_W-1:0]   Z_THRESHOLD_RESET   = 31'd15729;
  localparam logic [THR_W-1:0]   NOISE_FLOOR_RESET   = 31'd315;
  localparam logic [DELAY_W-1:0] HOLDOFF_DELAY_RESET = 8'd8;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_BUMP   = 1'b1;

  // one classified sample handed from the front to the back
  typedef struct packed {
    logic [SENSOR_W-1:0] sensor;
    logic [POS_W-1:0]    pos_x;
    logic [POS_W-1:0]    pos_y;
    logic [POS_W-1:0]    pos_z;
    logic [POS_W-1:0]    angle_z;
    logic [POS_W-1:0]    angle_y;
    logic [POS_W-1:0]    angle_x;
    logic [MAG_W-1:0]    mag_x;
    logic [MAG_W-1:0]    mag_y;
    logic [MAG_W-1:0]    mag_z;
    logic                big;
    logic                bump;
    logic [PEAK_W-1:0]   peak;
  } entry_t;

endpackage

[rtl/mgbd_front.sv]
`timescale 1ns / 1ps

module mgbd_front #(
  parameter int unsigned MAX_SENSORS = mgbd_pkg::MAX_SENSORS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [mgbd_pkg::SENSOR_W-1:0]       sensor,
  input  logic signed [mgbd_pkg::POS_W-1:0]   pos_x,
  input  logic signed [mgbd_pkg::POS_W-1:0]   pos_y,
  input  logic signed [mgbd_pkg::POS_W-1:0]   pos_z,
  input  logic signed [mgbd_pkg::POS_W-1:0]   angle_z,
  input  logic signed [mgbd_pkg::POS_W-1:0]   angle_y,
  input  logic signed [mgbd_pkg::POS_W-1:0]   angle_x,
  input  logic [mgbd_pkg::THR_W-1:0]          z_threshold,
  input  logic [mgbd_pkg::DELAY_W-1:0]        holdoff_delay,
  input  logic                                q_full,
  output logic                                q_push,
  output mgbd_pkg::entry_t                    q_entry
);

  localparam int unsigned IDX_W = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
  localparam int unsigned EXT_W = IDX_W + mgbd_pkg::SENSOR_W;
  localparam int unsigned D_W   = mgbd_pkg::POS_W + 1;

  logic [MAX_SENSORS-1:0]             primed;
  logic signed [mgbd_pkg::POS_W-1:0]  prev_x [MAX_SENSORS];
  logic signed [mgbd_pkg::POS_W-1:0]  prev_y [MAX_SENSORS];
  logic signed [mgbd_pkg::POS_W-1:0]  prev_z [MAX_SENSORS];
  logic                               armed [MAX_SENSORS];
  logic [mgbd_pkg::PEAK_W-1:0]        peak [MAX_SENSORS];
  logic [mgbd_pkg::DELAY_W-1:0]       holdoff [MAX_SENSORS];

  logic [EXT_W-1:0]              sensor_ext;
  logic                          in_range;
  logic [IDX_W-1:0]              idx;
  logic                          accept;
  logic                          is_primed;
  logic signed [D_W-1:0]         dx, dy, dz;
  logic [D_W-1:0]                ax, ay, az;
  logic signed [D_W-1:0]         thr;
  logic signed [D_W:0]           dz2, thr2;
  logic                          gt;
  logic                          armed_n;
  logic [mgbd_pkg::PEAK_W-1:0]   peak_max;
  logic                          hold_zero;
  logic                          bump_cond;
  logic [mgbd_pkg::DELAY_W-1:0]  delay_m1, delay_m2;

  always_comb begin
    sensor_ext = EXT_W'(sensor);
    in_range   = sensor_ext < EXT_W'(MAX_SENSORS);
    idx        = sensor_ext[IDX_W-1:0];
    in_stall   = q_full;
    accept     = in_valid && !q_full;
    is_primed  = primed[idx];

    dx = {pos_x[mgbd_pkg::POS_W-1], pos_x} - {prev_x[idx][mgbd_pkg::POS_W-1], prev_x[idx]};
    dy = {pos_y[mgbd_pkg::POS_W-1], pos_y} - {prev_y[idx][mgbd_pkg::POS_W-1], prev_y[idx]};
    dz = {pos_z[mgbd_pkg::POS_W-1], pos_z} - {prev_z[idx][mgbd_pkg::POS_W-1], prev_z[idx]};
    ax = dx[D_W-1] ? D_W'(-dx) : D_W'(dx);
    ay = dy[D_W-1] ? D_W'(-dy) : D_W'(dy);
    az = dz[D_W-1] ? D_W'(-dz) : D_W'(dz);

    // bump step, valid only when the holdoff has run out
    thr       = $signed({2'b00, z_threshold});
    gt        = dz > thr;
    armed_n   = armed[idx] || gt;
    peak_max  = (gt && (peak[idx] < $unsigned(dz))) ? $unsigned(dz) : peak[idx];
    dz2       = {dz, 1'b0};
    thr2      = {1'b0, thr};
    hold_zero = (holdoff[idx] == '0);
    bump_cond = armed_n && (dz2 < thr2);

    delay_m1 = (holdoff_delay != '0) ? holdoff_delay - 8'd1 : '0;
    delay_m2 = (holdoff_delay >= 8'd2) ? holdoff_delay - 8'd2 : '0;

    q_push          = accept && in_range && is_primed;
    q_entry.sensor  = sensor;
    q_entry.pos_x   = pos_x;
    q_entry.pos_y   = pos_y;
    q_entry.pos_z   = pos_z;
    q_entry.angle_z = angle_z;
    q_entry.angle_y = angle_y;
    q_entry.angle_x = angle_x;
    q_entry.mag_x   = ax[mgbd_pkg::MAG_W-1:0];
    q_entry.mag_y   = ay[mgbd_pkg::MAG_W-1:0];
    q_entry.mag_z   = az[mgbd_pkg::MAG_W-1:0];
    // any axis step of 2^31 or more always passes the noise gate
    q_entry.big     = (|ax[D_W-1:mgbd_pkg::MAG_W]) || (|ay[D_W-1:mgbd_pkg::MAG_W]) ||
                      (|az[D_W-1:mgbd_pkg::MAG_W]);
    q_entry.bump    = hold_zero && bump_cond;
    q_entry.peak    = peak_max;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      primed <= '0;
    end else if (accept && in_range) begin
      primed[idx] <= 1'b1;
    end
  end

  // per-sensor state beyond primed is always written on the priming sample
  always_ff @(posedge clk) begin
    if (accept && in_range) begin
      prev_x[idx] <= pos_x;
      prev_y[idx] <= pos_y;
      prev_z[idx] <= pos_z;
      if (!is_primed) begin
        armed[idx]   <= 1'b0;
        peak[idx]    <= '0;
        holdoff[idx] <= delay_m2;
      end else if (!hold_zero) begin
        holdoff[idx] <= holdoff[idx] - 8'd1;
      end else if (bump_cond) begin
        armed[idx]   <= 1'b0;
        peak[idx]    <= '0;
        holdoff[idx] <= delay_m1;
      end else begin
        armed[idx] <= armed_n;
        peak[idx]  <= armed_n ? peak_max : '0;
      end
    end
  end

endmodule

[rtl/mgbd_queue.sv]
`timescale 1ns / 1ps

module mgbd_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  mgbd_pkg::entry_t  push_entry,
  input  logic              pop,
  output mgbd_pkg::entry_t  head,
  output logic              empty,
  output logic              full
);

  localparam int unsigned DEPTH = mgbd_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  mgbd_pkg::entry_t  slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign head  = slots[rd_ptr];
  assign empty = (count == '0);
  assign full  = (count == CNT_W'(DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("request pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("pop from an empty queue");
`endif

endmodule

[rtl/mgbd_back.sv]
`timescale 1ns / 1ps

module mgbd_back (
  input  logic                                clk,
  input  logic                                rst,
  input  mgbd_pkg::entry_t                    q_head,
  input  logic                                q_empty,
  output logic                                q_pop,
  input  logic [mgbd_pkg::THR_W-1:0]          noise_floor,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                kind,
  output logic [mgbd_pkg::SENSOR_W-1:0]       sensor_out,
  output logic signed [mgbd_pkg::POS_W-1:0]   out_x,
  output logic signed [mgbd_pkg::POS_W-1:0]   out_y,
  output logic signed [mgbd_pkg::POS_W-1:0]   out_z,
  output logic signed [mgbd_pkg::POS_W-1:0]   out_angle_z,
  output logic signed [mgbd_pkg::POS_W-1:0]   out_angle_y,
  output logic signed [mgbd_pkg::POS_W-1:0]   out_angle_x,
  output logic [mgbd_pkg::PEAK_W-1:0]         peak_rise,
  output logic                                last
);

  localparam int unsigned SUM_W = mgbd_pkg::SQ_W + 2;

  // square stage
  logic                          m_valid;
  logic                          m_phase;
  mgbd_pkg::entry_t              m_item;
  logic [mgbd_pkg::SQ_W-1:0]     m_sx, m_sy, m_sz, m_nn;

  logic [SUM_W-1:0]  sum;
  logic              fwd;
  logic              out_free;
  logic              emit_fwd;
  logic              emit_bump;
  logic              load_out;
  logic              m_done;
  logic              m_load;

  always_comb begin
    sum       = SUM_W'(m_sx) + SUM_W'(m_sy) + SUM_W'(m_sz);
    fwd       = m_item.big || (sum > SUM_W'(m_nn));
    out_free  = !out_valid || !out_stall;
    emit_fwd  = m_valid && !m_phase && fwd;
    emit_bump = m_valid && m_item.bump && (m_phase || !fwd);
    load_out  = out_free && (emit_fwd || emit_bump);
    // a sample with both results stays in the square stage until its bump leaves
    m_done    = m_valid && ((!fwd && !m_item.bump) ||
                            (out_free && !(emit_fwd && m_item.bump)));
    m_load    = !q_empty && (!m_valid || m_done);
    q_pop     = m_load;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
      m_phase <= 1'b0;
    end else begin
      if (m_load) begin
        m_valid <= 1'b1;
        m_phase <= 1'b0;
      end else if (m_done) begin
        m_valid <= 1'b0;
        m_phase <= 1'b0;
      end else if (out_free && emit_fwd && m_item.bump) begin
        m_phase <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (m_load) begin
      m_item <= q_head;
      m_sx   <= q_head.mag_x * q_head.mag_x;
      m_sy   <= q_head.mag_y * q_head.mag_y;
      m_sz   <= q_head.mag_z * q_head.mag_z;
      m_nn   <= noise_floor * noise_floor;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      sensor_out <= m_item.sensor;
      if (emit_fwd) begin
        kind        <= mgbd_pkg::KIND_SAMPLE;
        out_x       <= m_item.pos_x;
        out_y       <= m_item.pos_y;
        out_z       <= m_item.pos_z;
        out_angle_z <= m_item.angle_z;
        out_angle_y <= m_item.angle_y;
        out_angle_x <= m_item.angle_x;
        peak_rise   <= '0;
        last        <= !m_item.bump;
      end else begin
        kind        <= mgbd_pkg::KIND_BUMP;
        out_x       <= '0;
        out_y       <= '0;
        out_z       <= '0;
        out_angle_z <= '0;
        out_angle_y <= '0;
        out_angle_x <= '0;
        peak_rise   <= m_item.peak;
        last        <= 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_phase_needs_bump: assert property (@(posedge clk) disable iff (rst)
    m_phase |-> (m_valid && m_item.bump))
    else $error("second result pending without a bump");
  a_first_of_two_not_last: assert property (@(posedge clk) disable iff (rst)
    (load_out && emit_fwd && m_item.bump) |=> (out_valid && !last))
    else $error("forwarded sample marked last while a bump follows");
  a_bump_result_last: assert property (@(posedge clk) disable iff (rst)
    (load_out && !emit_fwd) |=> (out_valid && last && kind == mgbd_pkg::KIND_BUMP))
    else $error("bump result not marked last");
`endif

endmodule

[rtl/motion_gate_and_bump_detector_core.sv]
`timescale 1ns / 1ps

// Motion gate and bump detector for tracker samples.
// Input channel: in_valid / in_stall carry one sample (sensor index, position and
// three angles, signed Q11.20). A request is taken on a clock edge with in_valid
// high and in_stall low. Output channel: out_valid / out_stall carry results; each
// sample gives zero, one or two results (forwarded sample first, then bump), and
// the final one of a sample has last set.
// Results pass the queue, square stage and output register. Throughput: one sample
// and one result per cycle when neither side stalls; a sample with two results holds
// the square stage until its bump leaves, and the four-entry queue between the
// per-sensor classifier and the output stage soaks that up. in_stall rises only when
// that queue is full. When the receiver stalls, the output register holds its result
// and the queue fills behind it. The user must write configuration (cfg_we,
// cfg_index, cfg_data) only while the block is idle; the block does not enforce it.
// Reset restores the register defaults and clears all per-sensor priming, so the
// next sample of every sensor only primes it.

module motion_gate_and_bump_detector_core #(
  parameter int unsigned MAX_SENSORS = mgbd_pkg::MAX_SENSORS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [mgbd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mgbd_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [mgbd_pkg::SENSOR_W-1:0]       sensor,
  input  logic signed [mgbd_pkg::POS_W-1:0]   pos_x,
  input  logic signed [mgbd_pkg::POS_W-1:0]   pos_y,
  input  logic signed [mgbd_pkg::POS_W-1:0]   pos_z,
  input  logic signed [mgbd_pkg::POS_W-1:0]   angle_z,
  input  logic signed [mgbd_pkg::POS_W-1:0]   angle_y,
  input  logic signed [mgbd_pkg::POS_W-1:0]   angle_x,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                kind,
  output logic [mgbd_pkg::SENSOR_W-1:0]       sensor_out,
  output logic signed [mgbd_pkg::POS_W-1:0]   out_x,
  output logic signed [mgbd_pkg::POS_W-1:0]   out_y,
  output logic signed [mgbd_pkg::POS_W-1:0]   out_z,
  output logic signed [mgbd_pkg::POS_W-1:0]   out_angle_z,
  output logic signed [mgbd_pkg::POS_W-1:0]   out_angle_y,
  output logic signed [mgbd_pkg::POS_W-1:0]   out_angle_x,
  output logic [mgbd_pkg::PEAK_W-1:0]         peak_rise,
  output logic                                last
);

  logic [mgbd_pkg::THR_W-1:0]    z_threshold;
  logic [mgbd_pkg::THR_W-1:0]    noise_floor;
  logic [mgbd_pkg::DELAY_W-1:0]  holdoff_delay;

  logic              q_push;
  logic              q_pop;
  logic              q_empty;
  logic              q_full;
  mgbd_pkg::entry_t  q_entry;
  mgbd_pkg::entry_t  q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      z_threshold   <= mgbd_pkg::Z_THRESHOLD_RESET;
      noise_floor   <= mgbd_pkg::NOISE_FLOOR_RESET;
      holdoff_delay <= mgbd_pkg::HOLDOFF_DELAY_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mgbd_pkg::CFG_Z_THRESHOLD: begin
          z_threshold <= cfg_data;
        end
        mgbd_pkg::CFG_NOISE_FLOOR: begin
          noise_floor <= cfg_data;
        end
        mgbd_pkg::CFG_HOLDOFF_DELAY: begin
          holdoff_delay <= cfg_data[mgbd_pkg::DELAY_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  mgbd_front #(
    .MAX_SENSORS (MAX_SENSORS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .sensor        (sensor),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .pos_z         (pos_z),
    .angle_z       (angle_z),
    .angle_y       (angle_y),
    .angle_x       (angle_x),
    .z_threshold   (z_threshold),
    .holdoff_delay (holdoff_delay),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_entry       (q_entry)
  );

  mgbd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty),
    .full       (q_full)
  );

  mgbd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_head      (q_head),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .noise_floor (noise_floor),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .sensor_out  (sensor_out),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_z       (out_z),
    .out_angle_z (out_angle_z),
    .out_angle_y (out_angle_y),
    .out_angle_x (out_angle_x),
    .peak_rise   (peak_rise),
    .last        (last)
  );

endmodule

[bench/mgbd_checker.sv]
`timescale 1ns / 1ps

module mgbd_checker #(
  parameter int unsigned MAX_SENSORS = mgbd_pkg::MAX_SENSORS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [mgbd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mgbd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [mgbd_pkg::SENSOR_W-1:0]   sensor,
  input  logic [mgbd_pkg::POS_W-1:0]      pos_x,
  input  logic [mgbd_pkg::POS_W-1:0]      pos_y,
  input  logic [mgbd_pkg::POS_W-1:0]      pos_z,
  input  logic [mgbd_pkg::POS_W-1:0]      angle_z,
  input  logic [mgbd_pkg::POS_W-1:0]      angle_y,
  input  logic [mgbd_pkg::POS_W-1:0]      angle_x,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic                            kind,
  input  logic [mgbd_pkg::SENSOR_W-1:0]   sensor_out,
  input  logic [mgbd_pkg::POS_W-1:0]      out_x,
  input  logic [mgbd_pkg::POS_W-1:0]      out_y,
  input  logic [mgbd_pkg::POS_W-1:0]      out_z,
  input  logic [mgbd_pkg::POS_W-1:0]      out_angle_z,
  input  logic [mgbd_pkg::POS_W-1:0]      out_angle_y,
  input  logic [mgbd_pkg::POS_W-1:0]      out_angle_x,
  input  logic [mgbd_pkg::PEAK_W-1:0]     peak_rise,
  input  logic                            last,
  output int                              pending,
  output int                              failures,
  output int                              fwd_seen,
  output int                              bumps_seen
);

  typedef struct packed {
    logic                          kind;
    logic [mgbd_pkg::SENSOR_W-1:0] sensor;
    logic [mgbd_pkg::POS_W-1:0]    x;
    logic [mgbd_pkg::POS_W-1:0]    y;
    logic [mgbd_pkg::POS_W-1:0]    z;
    logic [mgbd_pkg::POS_W-1:0]    ang_z;
    logic [mgbd_pkg::POS_W-1:0]    ang_y;
    logic [mgbd_pkg::POS_W-1:0]    ang_x;
    logic [mgbd_pkg::PEAK_W-1:0]   peak;
    logic                          last;
  } result_t;

  result_t expected_q[$];

  logic [mgbd_pkg::THR_W-1:0]   thr_reg;
  logic [mgbd_pkg::THR_W-1:0]   noise_reg;
  logic [mgbd_pkg::DELAY_W-1:0] delay_reg;

  longint track_x[MAX_SENSORS];
  longint track_y[MAX_SENSORS];
  longint track_z[MAX_SENSORS];
  longint peak_track[MAX_SENSORS];
  bit     primed_t[MAX_SENSORS];
  bit     armed_t[MAX_SENSORS];
  int     holdoff_t[MAX_SENSORS];

  int fail_count = 0;
  int fwd_count = 0;
  int bump_count = 0;

  function automatic longint magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  task automatic clear_tracking();
    thr_reg = mgbd_pkg::Z_THRESHOLD_RESET;
    noise_reg = mgbd_pkg::NOISE_FLOOR_RESET;
    delay_reg = mgbd_pkg::HOLDOFF_DELAY_RESET;
    for (int i = 0; i < MAX_SENSORS; i++) begin
      track_x[i] = 0;
      track_y[i] = 0;
      track_z[i] = 0;
      peak_track[i] = 0;
      primed_t[i] = 0;
      armed_t[i] = 0;
      holdoff_t[i] = 0;
    end
  endtask

  task automatic predict_sample(input logic [mgbd_pkg::SENSOR_W-1:0] s,
                                input logic [mgbd_pkg::POS_W-1:0] px,
                                input logic [mgbd_pkg::POS_W-1:0] py,
                                input logic [mgbd_pkg::POS_W-1:0] pz,
                                input logic [mgbd_pkg::POS_W-1:0] az,
                                input logic [mgbd_pkg::POS_W-1:0] ay,
                                input logic [mgbd_pkg::POS_W-1:0] ax);
    longint nx, ny, nz, dx, dy, dz, thr, mx, my, mz;
    longint unsigned sum, lim;
    bit moved, bumped;
    result_t fwd, bump;
    nx = longint'($signed(px));
    ny = longint'($signed(py));
    nz = longint'($signed(pz));
    if (s < MAX_SENSORS) begin
      if (!primed_t[s]) begin
        track_x[s] = nx;
        track_y[s] = ny;
        track_z[s] = nz;
        primed_t[s] = 1;
        armed_t[s] = 0;
        peak_track[s] = 0;
        holdoff_t[s] = (delay_reg >= 2) ? int'(delay_reg) - 2 : 0;
      end else begin
        dx = nx - track_x[s];
        dy = ny - track_y[s];
        dz = nz - track_z[s];
        track_x[s] = nx;
        track_y[s] = ny;
        track_z[s] = nz;

        mx = magnitude(dx);
        my = magnitude(dy);
        mz = magnitude(dz);
        if (mx >= 64'h8000_0000 || my >= 64'h8000_0000 || mz >= 64'h8000_0000) begin
          moved = 1;
        end else begin
          sum = longint'(mx) * mx;
          sum = sum + longint'(my) * my + longint'(mz) * mz;
          lim = 64'(noise_reg);
          lim = lim * lim;
          moved = (sum > lim);
        end

        bumped = 0;
        bump = '0;
        if (holdoff_t[s] != 0) begin
          holdoff_t[s] = holdoff_t[s] - 1;
        end else begin
          thr = longint'(thr_reg);
          if (dz > thr) begin
            armed_t[s] = 1;
            if (peak_track[s] < dz) peak_track[s] = dz;
          end
          if (!armed_t[s]) begin
            peak_track[s] = 0;
          end else if (2 * dz < thr) begin
            bumped = 1;
            bump.kind = mgbd_pkg::KIND_BUMP;
            bump.sensor = s;
            bump.peak = peak_track[s][mgbd_pkg::PEAK_W-1:0];
            bump.last = 1'b1;
            armed_t[s] = 0;
            peak_track[s] = 0;
            holdoff_t[s] = (delay_reg >= 1) ? int'(delay_reg) - 1 : 0;
          end
        end

        if (moved) begin
          fwd = '0;
          fwd.kind = mgbd_pkg::KIND_SAMPLE;
          fwd.sensor = s;
          fwd.x = px;
          fwd.y = py;
          fwd.z = pz;
          fwd.ang_z = az;
          fwd.ang_y = ay;
          fwd.ang_x = ax;
          fwd.last = !bumped;
          expected_q.push_back(fwd);
        end
        if (bumped) expected_q.push_back(bump);
      end
    end
  endtask

  function automatic bit field_differs(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  task automatic compare_result();
    result_t want;
    bit bad;
    want = expected_q.pop_front();
    bad = 0;
    bad |= field_differs("kind", 64'(want.kind), 64'(kind));
    bad |= field_differs("sensor_out", 64'(want.sensor), 64'(sensor_out));
    bad |= field_differs("out_x", 64'(want.x), 64'(out_x));
    bad |= field_differs("out_y", 64'(want.y), 64'(out_y));
    bad |= field_differs("out_z", 64'(want.z), 64'(out_z));
    bad |= field_differs("out_angle_z", 64'(want.ang_z), 64'(out_angle_z));
    bad |= field_differs("out_angle_y", 64'(want.ang_y), 64'(out_angle_y));
    bad |= field_differs("out_angle_x", 64'(want.ang_x), 64'(out_angle_x));
    bad |= field_differs("peak_rise", 64'(want.peak), 64'(peak_rise));
    bad |= field_differs("last", 64'(want.last), 64'(last));
    if (bad) fail_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_tracking();
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mgbd_pkg::CFG_Z_THRESHOLD:   thr_reg = cfg_data[mgbd_pkg::THR_W-1:0];
          mgbd_pkg::CFG_NOISE_FLOOR:   noise_reg = cfg_data[mgbd_pkg::THR_W-1:0];
          mgbd_pkg::CFG_HOLDOFF_DELAY: delay_reg = cfg_data[mgbd_pkg::DELAY_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (kind === mgbd_pkg::KIND_BUMP) bump_count++;
        else fwd_count++;
        if (expected_q.size() == 0) begin
          $display("%0t: result with nothing expected, actual kind %b sensor %h",
                   $time, kind, sensor_out);
          fail_count++;
        end else begin
          compare_result();
        end
      end
      if (in_valid && !in_stall) begin
        predict_sample(sensor, pos_x, pos_y, pos_z, angle_z, angle_y, angle_x);
      end
    end
    pending <= expected_q.size();
    failures <= fail_count;
    fwd_seen <= fwd_count;
    bumps_seen <= bump_count;
  end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;

  localparam logic [mgbd_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [mgbd_pkg::POS_W-1:0] POS_MAX = 32'h7fff_ffff;
  localparam logic [mgbd_pkg::POS_W-1:0] POS_MIN = 32'h8000_0000;
  localparam logic [mgbd_pkg::CFG_DATA_W-1:0] REG_MAX = 31'h7fff_ffff;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 16;

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            cfg_we;
  logic [mgbd_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [mgbd_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                            in_valid;
  logic                            in_stall;
  logic [mgbd_pkg::SENSOR_W-1:0]   sensor;
  logic [mgbd_pkg::POS_W-1:0]      pos_x, pos_y, pos_z;
  logic [mgbd_pkg::POS_W-1:0]      angle_z, angle_y, angle_x;
  logic                            out_valid;
  logic                            out_stall;
  logic                            kind;
  logic [mgbd_pkg::SENSOR_W-1:0]   sensor_out;
  logic [mgbd_pkg::POS_W-1:0]      out_x, out_y, out_z;
  logic [mgbd_pkg::POS_W-1:0]      out_angle_z, out_angle_y, out_angle_x;
  logic [mgbd_pkg::PEAK_W-1:0]     peak_rise;
  logic                            last;

  int pending, failures, fwd_seen, bumps_seen;

  int unsigned send_idle_pct = 22;
  int unsigned recv_idle_pct = 22;
  int unsigned cur_thr = mgbd_pkg::Z_THRESHOLD_RESET;
  int unsigned cur_noise = mgbd_pkg::NOISE_FLOOR_RESET;
  bit hold_output = 1'b0;
  int holds_done = 0;
  int samples_sent = 0;
  int settings_used = 1;

  logic [mgbd_pkg::POS_W-1:0] walk_x[16];
  logic [mgbd_pkg::POS_W-1:0] walk_y[16];
  logic [mgbd_pkg::POS_W-1:0] walk_z[16];

  always #6 clk = ~clk;

  motion_gate_and_bump_detector_core u_top (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .sensor(sensor),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .angle_z(angle_z), .angle_y(angle_y), .angle_x(angle_x),
    .out_valid(out_valid), .out_stall(out_stall), .kind(kind), .sensor_out(sensor_out),
    .out_x(out_x), .out_y(out_y), .out_z(out_z),
    .out_angle_z(out_angle_z), .out_angle_y(out_angle_y), .out_angle_x(out_angle_x),
    .peak_rise(peak_rise), .last(last)
  );

  mgbd_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .sensor(sensor),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .angle_z(angle_z), .angle_y(angle_y), .angle_x(angle_x),
    .out_valid(out_valid), .out_stall(out_stall), .kind(kind), .sensor_out(sensor_out),
    .out_x(out_x), .out_y(out_y), .out_z(out_z),
    .out_angle_z(out_angle_z), .out_angle_y(out_angle_y), .out_angle_x(out_angle_x),
    .peak_rise(peak_rise), .last(last),
    .pending(pending), .failures(failures), .fwd_seen(fwd_seen), .bumps_seen(bumps_seen)
  );

  // receiver: random stalls, plus a long hold-off when asked
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_output) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_output = 1'b0;
        holds_done++;
      end
      out_stall = ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  task automatic write_reg(input logic [mgbd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mgbd_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // stop offering requests and let everything in flight come out
  task automatic quiesce();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_config(input logic [mgbd_pkg::CFG_DATA_W-1:0] thr,
                            input logic [mgbd_pkg::CFG_DATA_W-1:0] noise,
                            input logic [mgbd_pkg::CFG_DATA_W-1:0] delay);
    quiesce();
    write_reg(mgbd_pkg::CFG_Z_THRESHOLD, thr);
    write_reg(mgbd_pkg::CFG_NOISE_FLOOR, noise);
    write_reg(mgbd_pkg::CFG_HOLDOFF_DELAY, delay);
    cur_thr = thr;
    cur_noise = noise;
    settings_used++;
  endtask

  task automatic drive_sample(input logic [mgbd_pkg::SENSOR_W-1:0] s,
                              input logic [mgbd_pkg::POS_W-1:0] x,
                              input logic [mgbd_pkg::POS_W-1:0] y,
                              input logic [mgbd_pkg::POS_W-1:0] z,
                              input logic [mgbd_pkg::POS_W-1:0] az,
                              input logic [mgbd_pkg::POS_W-1:0] ay,
                              input logic [mgbd_pkg::POS_W-1:0] ax);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    sensor = s;
    pos_x = x;
    pos_y = y;
    pos_z = z;
    angle_z = az;
    angle_y = ay;
    angle_x = ax;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    samples_sent++;
  endtask

  function automatic logic [mgbd_pkg::POS_W-1:0] xy_step();
    logic [mgbd_pkg::POS_W-1:0] d;
    if ($urandom_range(0, 3) == 0) return '0;
    d = $urandom_range(0, 2 * cur_noise + 1);
    if ($urandom_range(0, 1)) d = -d;
    return d;
  endfunction

  // mostly plausible motion per sensor, the rest raw noise
  task automatic random_sample();
    logic [mgbd_pkg::SENSOR_W-1:0] s;
    logic [mgbd_pkg::POS_W-1:0] x, y, z;
    if ($urandom_range(0, 3) != 0) s = $urandom_range(0, 3);
    else s = $urandom_range(0, 15);
    if ($urandom_range(0, 9) < 7) begin
      x = walk_x[s] + xy_step();
      y = walk_y[s] + xy_step();
      case ($urandom_range(0, 3))
        0: z = walk_z[s] + $urandom_range(cur_thr + 1, 2 * cur_thr + 1);
        1: z = walk_z[s] + $urandom_range(0, cur_thr / 2);
        2: z = walk_z[s] - $urandom_range(0, cur_thr);
        default: z = walk_z[s];
      endcase
    end else begin
      x = $urandom;
      y = $urandom;
      z = $urandom;
    end
    walk_x[s] = x;
    walk_y[s] = y;
    walk_z[s] = z;
    drive_sample(s, x, y, z, $urandom, $urandom, $urandom);
  endtask

  task automatic run_random(input int count);
    repeat (count) random_sample();
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = mgbd_pkg::CFG_Z_THRESHOLD;
    cfg_data = '0;
    in_valid = 1'b0;
    sensor = '0;
    pos_x = '0;
    pos_y = '0;
    pos_z = '0;
    angle_z = '0;
    angle_y = '0;
    angle_x = '0;
    for (int i = 0; i < 16; i++) begin
      walk_x[i] = '0;
      walk_y[i] = '0;
      walk_z[i] = '0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // default registers: priming, full-scale jumps, noise edge, holdoff, a bump
    drive_sample(0, POS_MAX, POS_MIN, 0, POS_MAX, POS_MIN, 0);
    drive_sample(0, POS_MIN, POS_MAX, 0, POS_MIN, POS_MAX, 32'hffff_ffff);
    drive_sample(0, POS_MIN, POS_MAX, 0, 1, 2, 3);
    drive_sample(0, POS_MIN + 315, POS_MAX, 0, 4, 5, 6);
    drive_sample(0, POS_MIN + 631, POS_MAX, 0, 7, 8, 9);
    drive_sample(0, POS_MIN + 631, POS_MAX, 5, 0, 0, 0);
    drive_sample(0, POS_MIN + 631, POS_MAX, 5, 0, 0, 0);
    drive_sample(0, POS_MIN + 631, POS_MAX, 20005, 10, 11, 12);
    drive_sample(0, POS_MIN + 631, POS_MAX, 50005, 13, 14, 15);
    drive_sample(0, POS_MIN + 1631, POS_MAX, 50105, 16, 17, 18);
    drive_sample(15, 0, 0, POS_MAX, 0, 0, 0);
    drive_sample(15, 0, 0, POS_MIN, 0, 0, 0);

    // widest threshold, no noise floor, no holdoff; upper data bits dropped
    set_config(REG_MAX, 0, 31'h7fff_ff00);
    write_reg(CFG_UNUSED, 31'h1234_5678);
    drive_sample(1, 1, 1, POS_MIN, 0, 0, 0);
    drive_sample(1, 1, 1, 32'hffff_ffff, 0, 0, 0);
    drive_sample(1, 1, 1, POS_MAX, 0, 0, 0);
    drive_sample(1, 1, 1, POS_MAX, 0, 0, 0);
    drive_sample(1, 1, 1, POS_MAX, 0, 0, 0);

    // zero threshold, widest noise floor: largest peak, motion just at the floor
    set_config(0, REG_MAX, 1);
    drive_sample(2, 0, 0, POS_MIN, 0, 0, 0);
    drive_sample(2, 0, 0, POS_MAX, 0, 0, 0);
    drive_sample(2, 0, 0, POS_MAX, 0, 0, 0);
    drive_sample(2, POS_MAX, 0, POS_MAX, 0, 0, 0);
    drive_sample(2, POS_MAX, 1, POS_MAX - 1, 0, 0, 0);

    set_config(20000, 300, 2);
    run_random(150);

    set_config(5000, 0, 0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(150);
    send_idle_pct = 22;
    recv_idle_pct = 22;

    // output held off while requests keep coming, so the block backs up
    set_config(40000, 1000, 3);
    send_idle_pct = 0;
    hold_output = 1'b1;
    run_random(60);
    send_idle_pct = 22;
    run_random(90);

    set_config($urandom_range(0, REG_MAX), $urandom_range(0, REG_MAX), 255);
    run_random(150);

    set_config(1, REG_MAX, 1);
    run_random(150);

    set_config($urandom_range(100, 100000), $urandom_range(0, 5000), $urandom_range(0, 6));
    run_random(150);

    quiesce();
    $display("sent %0d samples over %0d register settings, %0d long output hold-offs",
             samples_sent, settings_used, holds_done);
    $display("checked %0d forwarded samples and %0d bump events", fwd_seen, bumps_seen);
    if (failures == 0 && pending == 0) begin
      $display("tb OK");
    end else begin
      if (pending != 0) $display("%0t: %0d expected results never arrived", $time, pending);
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #(3_000_000);
    $display("%0t: timeout", $time);
    $display("tb NOT OK");
    $finish;
  end

endmodule

[sim.f]
rtl/mgbd_pkg.sv
rtl/mgbd_front.sv
rtl/mgbd_queue.sv
rtl/mgbd_back.sv
rtl/motion_gate_and_bump_detector_core.sv
bench/mgbd_checker.sv
bench/tb.sv
